FILE: rtl/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the trajectory point assembler.
// ----------------------------------------------------------------------------
package tpa_pkg;

  // Default fixed-point format and step limit
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_MAX_STEP  = 10;

  // Field widths
  localparam int VAL_W  = 32;
  localparam int POS_W  = 41;
  localparam int KIN_W  = 48;
  localparam int DUR_W  = 16;
  localparam int CFG_W  = 32;
  localparam int CFG_IDX_W = 1;

  // Operation codes of a field write
  localparam logic [1:0] OP_POS = 2'd0;
  localparam logic [1:0] OP_VEL = 2'd1;
  localparam logic [1:0] OP_ACC = 2'd2;
  localparam logic [1:0] OP_SER = 2'd3;

  // Field mark bits
  localparam logic [3:0] MARK_POS = 4'h1;
  localparam logic [3:0] MARK_VEL = 4'h2;
  localparam logic [3:0] MARK_ACC = 4'h4;
  localparam logic [3:0] MARK_SER = 4'h8;
  localparam logic [3:0] MARK_ALL = 4'hF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_RATIO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 1'd1;

  // Completed point on its way to the scaling stage
  typedef struct packed {
    logic signed [VAL_W-1:0] pos;
    logic signed [VAL_W-1:0] vel;
    logic signed [VAL_W-1:0] acc;
    logic signed [DUR_W-1:0] dur;
  } point_t;

  // Motion target
  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [KIN_W-1:0] velocity;
    logic signed [KIN_W-1:0] acceleration;
    logic signed [DUR_W-1:0] duration;
    logic                    interp;
  } target_t;

endpackage

FILE: rtl/tpa_scale.sv
// ----------------------------------------------------------------------------
// tpa_scale
// Scales a completed point by the joint ratio: truncated Q32.16 velocity and
// acceleration, rounded-up position plus offset, near-zero velocity flag.
// ----------------------------------------------------------------------------
module tpa_scale #(
  parameter int FRAC_BITS = tpa_pkg::DEF_FRAC_BITS
) (
  input  tpa_pkg::point_t                       pt,
  input  logic signed [tpa_pkg::CFG_W-1:0]      ratio,
  input  logic signed [tpa_pkg::CFG_W-1:0]      offset,
  output tpa_pkg::target_t                      tgt
);
  import tpa_pkg::*;

  localparam int K2 = 2 * FRAC_BITS;
  localparam logic signed [64:0] RND_UP = (65'sd1 <<< K2) - 65'sd1;
  localparam logic [63:0] NEAR_ZERO = (64'd1 << K2) / 64'd10000;

  logic signed [63:0] pp;
  logic signed [63:0] pv;
  logic signed [63:0] pa;
  logic signed [64:0] p_rnd;
  logic signed [64:0] p_shift;
  logic signed [64:0] p_sum;
  logic signed [63:0] v_shift;
  logic signed [63:0] a_shift;
  logic        [63:0] v_mag;

  always_comb begin
    pp = 64'(pt.pos) * 64'(ratio);
    pv = 64'(pt.vel) * 64'(ratio);
    pa = 64'(pt.acc) * 64'(ratio);

    // ceiling of the position product, then the count offset
    p_rnd   = 65'(pp) + RND_UP;
    p_shift = p_rnd >>> K2;
    p_sum   = p_shift + 65'(offset);

    v_shift = pv >>> FRAC_BITS;
    a_shift = pa >>> FRAC_BITS;
    v_mag   = pv[63] ? 64'(-pv) : 64'(pv);

    tgt.position     = p_sum[POS_W-1:0];
    tgt.velocity     = v_shift[KIN_W-1:0];
    tgt.acceleration = a_shift[KIN_W-1:0];
    tgt.duration     = pt.dur;
    tgt.interp       = (v_mag > NEAR_ZERO);
  end

endmodule

FILE: rtl/trajectory_point_assembler.sv
// ----------------------------------------------------------------------------
// trajectory_point_assembler
// Builds trajectory points from field writes and emits scaled motion targets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one field write per transfer:
//   in_operation picks position, velocity, acceleration or serial number.
//   After all four fields of a point are written, the point completes; if its
//   position differs from the previous complete point, one motion target
//   leaves on the output channel (out_valid/out_stall).
//   A target passes the capture register, then scaling into the output
//   register; out_stall can hold it in either.
//   Throughput: one field write per cycle while in_stall is low; the three
//   ratio multipliers in the scaling stage set the cycle time.
//   cfg_we/cfg_index/cfg_wdata write joint_ratio (0) and lower_limit_offset
//   (1); write them only while no target is in flight.
//   Reset clears the current point, its marks, the last point and the
//   pipeline; joint_ratio returns to 1.0 and the offset to zero.
//   When out_stall holds a target, the capture stage fills and in_stall
//   rises in the same cycle as the stage ahead of it is blocked.
// ----------------------------------------------------------------------------
module trajectory_point_assembler #(
  parameter int FRAC_BITS = tpa_pkg::DEF_FRAC_BITS,
  parameter int MAX_STEP  = tpa_pkg::DEF_MAX_STEP
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [tpa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tpa_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_operation,
  input  logic signed [tpa_pkg::VAL_W-1:0]      in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tpa_pkg::POS_W-1:0]      out_target_position,
  output logic signed [tpa_pkg::KIN_W-1:0]      out_target_velocity,
  output logic signed [tpa_pkg::KIN_W-1:0]      out_target_acceleration,
  output logic signed [tpa_pkg::DUR_W-1:0]      out_step_duration,
  output logic                                  out_interp_type
);
  import tpa_pkg::*;

  localparam logic signed [VAL_W:0] DUR_MAX = (VAL_W+1)'(MAX_STEP);
  localparam logic signed [VAL_W:0] DUR_MIN = -(VAL_W+1)'(32768);
  localparam logic signed [DUR_W-1:0] DUR_ONE = DUR_W'(1);

  // configuration
  logic signed [CFG_W-1:0] ratio_r;
  logic signed [CFG_W-1:0] offset_r;

  // point under assembly and last complete point
  logic signed [VAL_W-1:0] cur_pos_r, cur_vel_r, cur_acc_r, cur_ser_r;
  logic signed [VAL_W-1:0] cur_pos_nxt, cur_vel_nxt, cur_acc_nxt, cur_ser_nxt;
  logic [3:0]              marks_r, marks_nxt;
  logic signed [VAL_W-1:0] last_pos_r, last_ser_r;

  // capture stage and output register
  logic    p_vld_r, p_vld_nxt;
  point_t  p_pt_r, p_pt_nxt;
  logic    out_valid_r, out_valid_nxt;
  target_t out_res_r;
  target_t scaled;

  logic in_xfer;
  logic out_ready;
  logic p_ready;
  logic complete;
  logic emit;
  logic signed [VAL_W:0] dur_diff;
  logic signed [DUR_W-1:0] dur_sat;

  assign out_ready = !out_valid_r || !out_stall;
  assign p_ready   = !p_vld_r || out_ready;
  assign in_stall  = !p_ready;
  assign in_xfer   = in_valid && p_ready;

  always_comb begin
    cur_pos_nxt = cur_pos_r;
    cur_vel_nxt = cur_vel_r;
    cur_acc_nxt = cur_acc_r;
    cur_ser_nxt = cur_ser_r;
    marks_nxt   = marks_r;
    unique case (in_operation)
      OP_POS: begin
        cur_pos_nxt = in_value;
        marks_nxt   = marks_r | MARK_POS;
      end
      OP_VEL: begin
        cur_vel_nxt = in_value;
        marks_nxt   = marks_r | MARK_VEL;
      end
      OP_ACC: begin
        cur_acc_nxt = in_value;
        marks_nxt   = marks_r | MARK_ACC;
      end
      OP_SER: begin
        cur_ser_nxt = in_value;
        marks_nxt   = marks_r | MARK_SER;
      end
      default: begin
        marks_nxt = marks_r;
      end
    endcase

    complete = (marks_nxt == MARK_ALL);
    emit     = complete && (cur_pos_nxt != last_pos_r);

    // serial difference: large gaps step by one, deep negatives saturate
    dur_diff = (VAL_W+1)'(cur_ser_nxt) - (VAL_W+1)'(last_ser_r);
    if (dur_diff > DUR_MAX) begin
      dur_sat = DUR_ONE;
    end else if (dur_diff < DUR_MIN) begin
      dur_sat = DUR_MIN[DUR_W-1:0];
    end else begin
      dur_sat = dur_diff[DUR_W-1:0];
    end

    p_pt_nxt.pos = cur_pos_nxt;
    p_pt_nxt.vel = cur_vel_nxt;
    p_pt_nxt.acc = cur_acc_nxt;
    p_pt_nxt.dur = dur_sat;

    if (in_xfer) begin
      p_vld_nxt = emit;
    end else if (out_ready) begin
      p_vld_nxt = 1'b0;
    end else begin
      p_vld_nxt = p_vld_r;
    end

    if (out_ready) begin
      out_valid_nxt = p_vld_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  tpa_scale #(
    .FRAC_BITS(FRAC_BITS)
  ) u_scale (
    .pt    (p_pt_r),
    .ratio (ratio_r),
    .offset(offset_r),
    .tgt   (scaled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= CFG_W'(65536);
      offset_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_JOINT_RATIO: ratio_r  <= cfg_wdata;
        REG_LOWER_LIMIT: offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r  <= '0;
      cur_vel_r  <= '0;
      cur_acc_r  <= '0;
      cur_ser_r  <= '0;
      marks_r    <= '0;
      last_pos_r <= '0;
      last_ser_r <= '0;
    end else if (in_xfer) begin
      if (complete) begin
        // point becomes the last point; start a fresh one
        last_pos_r <= cur_pos_nxt;
        last_ser_r <= cur_ser_nxt;
        cur_pos_r  <= '0;
        cur_vel_r  <= '0;
        cur_acc_r  <= '0;
        cur_ser_r  <= '0;
        marks_r    <= '0;
      end else begin
        cur_pos_r <= cur_pos_nxt;
        cur_vel_r <= cur_vel_nxt;
        cur_acc_r <= cur_acc_nxt;
        cur_ser_r <= cur_ser_nxt;
        marks_r   <= marks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      p_pt_r <= p_pt_nxt;
    end
    if (out_ready && p_vld_r) begin
      out_res_r <= scaled;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_target_position     = out_res_r.position;
  assign out_target_velocity     = out_res_r.velocity;
  assign out_target_acceleration = out_res_r.acceleration;
  assign out_step_duration       = out_res_r.duration;
  assign out_interp_type         = out_res_r.interp;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trajectory point assembler. Field writes go in
// over the valid/stall channel in random bursts while the target side stalls
// on its own pattern. A point assembler kept in the bench predicts each
// random target, directed rows carry theirs, and each target-side transfer
// is compared with the oldest expectation. A directed table covers clamps,
// rounding and the unchanged-position case. Random points with random field
// order and noise writes follow, under several joint ratio and offset settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpa_pkg::*;

  localparam int     FRAC            = DEF_FRAC_BITS;
  localparam longint ROUND_UP        = (longint'(1) <<< (2 * FRAC)) - 1;
  localparam longint NEAR_ZERO       = (longint'(1) <<< (2 * FRAC)) / 10000;
  localparam int     ITEMS_PER_PHASE = 135;
  localparam int     NUM_PHASES      = 8;
  localparam int     DRAIN_LIMIT     = 20000;
  localparam int     SETTLE_CYCLES   = 4;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_operation;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [POS_W-1:0] out_target_position;
  logic signed [KIN_W-1:0] out_target_velocity;
  logic signed [KIN_W-1:0] out_target_acceleration;
  logic signed [DUR_W-1:0] out_step_duration;
  logic                    out_interp_type;

  trajectory_point_assembler dut (.*);

  // Bench copy of the assembler state and registers
  logic signed [31:0] ratio;
  logic signed [31:0] offset;
  logic signed [31:0] pt_pos;
  logic signed [31:0] pt_vel;
  logic signed [31:0] pt_acc;
  logic signed [31:0] pt_ser;
  logic [3:0]         pt_marks;
  logic signed [31:0] prev_pos;
  logic signed [31:0] prev_ser;

  target_t expected_targets [$];

  int mismatch_count  = 0;
  int items_sent      = 0;
  int targets_checked = 0;
  int quiet_points    = 0;
  int settings_used   = 0;
  int burst_left      = 0;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] val;
    bit                 typed;
    target_t            tgt;
  } field_row_t;

  field_row_t directed_rows [25];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("trajectory_point_assembler test failed");
    $finish;
  end

  // Store one field; on a full point, work out the target it yields
  function automatic void assemble_field(input logic [1:0] op,
                                         input logic signed [31:0] val,
                                         output bit emitted, output target_t tgt);
    logic signed [63:0] prod_pos;
    logic signed [63:0] prod_vel;
    logic signed [63:0] prod_acc;
    logic signed [63:0] mag;
    longint             span;
    emitted = 1'b0;
    tgt = '0;
    case (op)
      OP_POS: begin pt_pos = val; pt_marks |= MARK_POS; end
      OP_VEL: begin pt_vel = val; pt_marks |= MARK_VEL; end
      OP_ACC: begin pt_acc = val; pt_marks |= MARK_ACC; end
      default: begin pt_ser = val; pt_marks |= MARK_SER; end
    endcase
    if (pt_marks == MARK_ALL) begin
      if (pt_pos != prev_pos) begin
        prod_pos = 64'(pt_pos) * 64'(ratio);
        prod_vel = 64'(pt_vel) * 64'(ratio);
        prod_acc = 64'(pt_acc) * 64'(ratio);
        // round position up, then add the offset and wrap to the port width
        tgt.position = POS_W'(((prod_pos + ROUND_UP) >>> (2 * FRAC)) + 64'(offset));
        tgt.velocity = KIN_W'(prod_vel >>> FRAC);
        tgt.acceleration = KIN_W'(prod_acc >>> FRAC);
        span = longint'(pt_ser) - longint'(prev_ser);
        if (span > DEF_MAX_STEP) span = 1;
        else if (span < -32768) span = -32768;
        tgt.duration = DUR_W'(span);
        mag = (prod_vel < 0) ? -prod_vel : prod_vel;
        tgt.interp = (mag > NEAR_ZERO);
        emitted = 1'b1;
      end else begin
        quiet_points++;
      end
      prev_pos = pt_pos;
      prev_ser = pt_ser;
      pt_pos = '0;
      pt_vel = '0;
      pt_acc = '0;
      pt_ser = '0;
      pt_marks = '0;
    end
  endfunction

  function automatic logic signed [31:0] corner();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_kin();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
      3: return corner();
      4: return $urandom_range(0, 20) - 10;  // around the near-zero velocity limit
      default: return $signed($urandom) >>> $urandom_range(0, 30);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_serial();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return corner();
      2: return prev_ser - 32'sd32768 + $urandom_range(0, 2) - 1;  // low clamp edge
      default: return prev_ser + $urandom_range(0, 56) - 44;
    endcase
  endfunction

  // Drive one field write, hold it until the transfer, then predict
  task automatic send_field(input logic [1:0] op, input logic signed [31:0] val,
                            input bit typed = 1'b0, input target_t typed_tgt = '0);
    int      gap;
    bit      emitted;
    target_t tgt;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
    items_sent++;
    assemble_field(op, val, emitted, tgt);
    if (emitted) expected_targets.push_back(typed ? typed_tgt : tgt);
  endtask

  // Four fields in random order, now and then one of them written twice
  task automatic send_point();
    logic [1:0]         ord [4];
    logic signed [31:0] fv [4];
    logic [1:0]         swap;
    int                 j;
    ord = '{OP_POS, OP_VEL, OP_ACC, OP_SER};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = ord[i];
      ord[i] = ord[j];
      ord[j] = swap;
    end
    fv[OP_POS] = ($urandom_range(0, 6) == 0) ? prev_pos : pick_kin();
    fv[OP_VEL] = pick_kin();
    fv[OP_ACC] = pick_kin();
    fv[OP_SER] = pick_serial();
    for (int i = 0; i < 4; i++) begin
      send_field(ord[i], fv[ord[i]]);
      if (i < 3 && $urandom_range(0, 6) == 0) begin
        j = $urandom_range(0, i);
        send_field(ord[j], pick_kin());
      end
    end
  endtask

  // Drop valid and wait for every predicted target to come out
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_targets.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_targets.size() != 0) begin
      $error("%0d expected targets never arrived", expected_targets.size());
      mismatch_count += expected_targets.size();
      expected_targets.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic signed [31:0] r, input logic signed [31:0] o);
    cfg_we    <= 1'b1;
    cfg_index <= REG_JOINT_RATIO;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_index <= REG_LOWER_LIMIT;
    cfg_wdata <= o;
    @(posedge clk);
    cfg_we <= 1'b0;
    ratio  = r;
    offset = o;
    settings_used++;
  endtask

  // Target side: stall pattern that changes its character every so often
  initial begin
    int mode      = 0;
    int mode_left = 0;
    int run_left  = 0;
    bit held      = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 4) != 0);
        default: begin
          if (run_left == 0) begin
            held = !held;
            run_left = held ? $urandom_range(5, 40) : $urandom_range(1, 4);
          end
          run_left--;
          out_stall <= held;
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_targets
    target_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_targets.size() == 0) begin
        $error("target transfer with nothing expected: position %0d",
               out_target_position);
        mismatch_count++;
      end else begin
        want = expected_targets.pop_front();
        targets_checked++;
        if (out_target_position !== want.position) begin
          $error("target_position: expected %0d, got %0d",
                 $signed(want.position), out_target_position);
          mismatch_count++;
        end
        if (out_target_velocity !== want.velocity) begin
          $error("target_velocity: expected %0d, got %0d",
                 $signed(want.velocity), out_target_velocity);
          mismatch_count++;
        end
        if (out_target_acceleration !== want.acceleration) begin
          $error("target_acceleration: expected %0d, got %0d",
                 $signed(want.acceleration), out_target_acceleration);
          mismatch_count++;
        end
        if (out_step_duration !== want.duration) begin
          $error("step_duration: expected %0d, got %0d",
                 $signed(want.duration), out_step_duration);
          mismatch_count++;
        end
        if (out_interp_type !== want.interp) begin
          $error("interp_type: expected %0d, got %0d", want.interp, out_interp_type);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int                 phase_first;
    logic signed [31:0] r;
    logic signed [31:0] o;

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_JOINT_RATIO;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_operation <= OP_POS;
    in_value     <= '0;
    ratio    = 32'sh0001_0000;
    offset   = '0;
    pt_pos   = '0;
    pt_vel   = '0;
    pt_acc   = '0;
    pt_ser   = '0;
    pt_marks = '0;
    prev_pos = '0;
    prev_ser = '0;

    // Reset register values: ratio 1.0, no offset
    directed_rows = '{
      '{OP_POS, 32'h0001_0000, 1'b0, '0},
      '{OP_VEL, 32'h0002_0000, 1'b0, '0},
      '{OP_ACC, 32'hFFFF_0000, 1'b0, '0},
      '{OP_SER, 32'd10,        1'b1, '{41'sd1, 48'sd131072, -48'sd65536, 16'sd10, 1'b1}},
      // position rewritten back to the last one: point completes silently
      '{OP_POS, 32'h0000_0003, 1'b0, '0},
      '{OP_POS, 32'h0001_0000, 1'b0, '0},
      '{OP_SER, 32'd7,         1'b0, '0},
      '{OP_VEL, 32'h0000_0000, 1'b0, '0},
      '{OP_ACC, 32'h0000_0000, 1'b0, '0},
      // step of 11 falls back to 1, velocity just under the near-zero limit
      '{OP_VEL, 32'd6,         1'b0, '0},
      '{OP_ACC, 32'h0000_0000, 1'b0, '0},
      '{OP_POS, 32'h0001_8001, 1'b0, '0},
      '{OP_SER, 32'd18,        1'b1, '{41'sd2, 48'sd6, 48'sd0, 16'sd1, 1'b0}},
      '{OP_ACC, 32'h8000_0000, 1'b0, '0},
      '{OP_SER, -32'sd32750,   1'b0, '0},
      '{OP_VEL, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_POS, 32'h8000_0000, 1'b1, '{-41'sd32768, 48'sd2147483647, -48'sd2147483648,
                                       -16'sd32768, 1'b1}},
      '{OP_POS, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_VEL, 32'd7,         1'b0, '0},
      '{OP_ACC, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_SER, 32'h8000_0000, 1'b1, '{41'sd32768, 48'sd7, 48'sd2147483647,
                                       -16'sd32768, 1'b1}},
      '{OP_SER, 32'h7FFF_FFFF, 1'b0, '0},
      '{OP_POS, 32'h0000_0000, 1'b0, '0},
      '{OP_VEL, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_ACC, 32'hFFFF_FFFF, 1'b1, '{41'sd0, -48'sd1, -48'sd1, 16'sd1, 1'b0}}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_field(directed_rows[i].op, directed_rows[i].val,
                 directed_rows[i].typed, directed_rows[i].tgt);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin r = 32'h7FFF_FFFF; o = 32'h7FFF_FFFF; end
        1: begin r = 32'h8000_0000; o = 32'h8000_0000; end
        2: begin r = 32'h0000_0000; o = $urandom; end
        3: begin r = 32'h0001_0000; o = 32'h0000_0000; end
        default: begin
          r = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h6_0000) - 32'h3_0000;
          o = $urandom;
        end
      endcase
      write_settings(r, o);
      phase_first = items_sent;
      while (items_sent - phase_first < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) send_field(2'($urandom_range(0, 3)), $urandom);
        else
          send_point();
      end
      drain();
    end

    $display("Covered %0d field transfers and %0d checked targets; %0d points completed",
             items_sent, targets_checked, quiet_points);
    $display("without a target (unchanged position), across %0d ratio/offset settings",
             settings_used);
    if (mismatch_count == 0) begin
      $display("trajectory_point_assembler test passed");
    end else begin
      $display("trajectory_point_assembler test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tpa_pkg.sv
rtl/tpa_scale.sv
rtl/trajectory_point_assembler.sv
verif/tb_top.sv
